FILE: rtl/tli_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the table linear interpolator.
package tli_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = 7;
	localparam int DATA_W = 32;
	localparam int QBITS = 35;
	localparam int DCNT_W = $clog2(QBITS);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [5:0] entry_index;
		logic signed [31:0] sample_x;
		logic signed [31:0] sample_y;
		logic signed [31:0] query_x;
	} tli_in_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic saturated;
	} tli_out_t;

	typedef enum logic [2:0] {
		RA_ZERO,
		RA_LAST,
		RA_MID,
		RA_A,
		RA_A1
	} raddr_sel_t;

	typedef struct packed {
		logic load_wr;
		logic start;
		raddr_sel_t raddr;
		logic seg_first;
		logic seg_last;
		logic seg_lo;
		logic srch_upd;
		logic cap_a;
		logic cap_a1;
		logic diff;
		logic mul;
		logic div_init;
		logic div_step;
		logic finish;
	} tli_cmd_t;

	typedef struct packed {
		logic x_le;
		logic x_ge;
		logic span_gt1;
		logic div_last;
		logic out_busy;
	} tli_sts_t;

endpackage

FILE: rtl/tli_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/tli_datapath.sv
`timescale 1ns / 1ps
// Datapath: sample tables, search registers, multiplier, divider and result register.
module tli_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tli_pkg::tli_in_t          req,
	input  logic                      cfg_we,
	input  logic [tli_pkg::CNT_W-1:0] cfg_data,
	input  tli_pkg::tli_cmd_t         cmd,
	output tli_pkg::tli_sts_t         sts,
	output tli_pkg::tli_out_t         res,
	output logic                      res_valid,
	input  logic                      res_stall
);
	import tli_pkg::*;

	localparam logic [QBITS-1:0] QMAX = QBITS'(1) << (QBITS - 1);
	localparam logic signed [DATA_W+4:0] SMAX = (DATA_W+5)'(32'sh7FFFFFFF);
	localparam logic signed [DATA_W+4:0] SMIN = -(DATA_W+5)'(64'sh80000000);

	function automatic logic [DATA_W-1:0] mag33(input logic signed [DATA_W:0] v);
		logic signed [DATA_W:0] n;
		n = -v;
		return v[DATA_W] ? n[DATA_W-1:0] : v[DATA_W-1:0];
	endfunction

	logic [CNT_W-1:0] cnt_q;
	logic res_valid_q;
	tli_out_t res_q;

	logic signed [DATA_W-1:0] x_q;
	logic [IDX_W-1:0] last_q, lo_q, hi_q, a_q;
	logic b_hi_q;
	logic signed [DATA_W-1:0] xa_q, ya_q, xa1_q, ya1_q;
	logic signed [DATA_W:0] dy_q, dx_q, ex_q;
	logic [2*DATA_W-1:0] num_q;
	logic neg_q, dxz_q, ovf_q;
	logic [DATA_W-1:0] dmag_q, rem_q;
	logic [QBITS-1:0] nsh_q, quo_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [IDX_W:0] lohi_sum;
	logic [IDX_W-1:0] mid, a1, raddr, last_n;
	logic [DATA_W-1:0] rx, ry;
	logic signed [DATA_W-1:0] xb, yb;
	logic [DATA_W:0] trial;
	logic trial_ge;
	logic [QBITS-1:0] qc;
	logic signed [DATA_W+4:0] sum;
	tli_out_t res_n;

	assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = lohi_sum[IDX_W:1];
	assign a1 = a_q + IDX_W'(1);

	always_comb begin
		if (cnt_q < CNT_W'(2)) begin
			last_n = IDX_W'(1);
		end else if (cnt_q > CNT_W'(TABLE_DEPTH)) begin
			last_n = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			last_n = IDX_W'(cnt_q - CNT_W'(1));
		end
	end

	always_comb begin
		case (cmd.raddr)
			RA_ZERO: raddr = '0;
			RA_LAST: raddr = last_q;
			RA_MID:  raddr = mid;
			RA_A:    raddr = a_q;
			RA_A1:   raddr = a1;
			default: raddr = '0;
		endcase
	end

	tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_xram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (req.entry_index),
		.wdata (req.sample_x),
		.raddr (raddr),
		.rdata (rx)
	);

	tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_yram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (req.entry_index),
		.wdata (req.sample_y),
		.raddr (raddr),
		.rdata (ry)
	);

	assign xb = b_hi_q ? xa1_q : xa_q;
	assign yb = b_hi_q ? ya1_q : ya_q;

	assign trial = {rem_q, nsh_q[QBITS-1]};
	assign trial_ge = trial >= {1'b0, dmag_q};

	always_comb begin
		qc = (ovf_q || quo_q > QMAX) ? QMAX : quo_q;
		sum = (DATA_W+5)'(yb) + (neg_q ? -$signed({2'b0, qc}) : $signed({2'b0, qc}));
		res_n.saturated = 1'b0;
		res_n.interp_value = sum[DATA_W-1:0];
		if (dxz_q) begin
			res_n.saturated = 1'b1;
			if (num_q == '0) begin
				res_n.interp_value = yb;
			end else if (neg_q) begin
				res_n.interp_value = SMIN[DATA_W-1:0];
			end else begin
				res_n.interp_value = SMAX[DATA_W-1:0];
			end
		end else if (sum > SMAX) begin
			res_n.saturated = 1'b1;
			res_n.interp_value = SMAX[DATA_W-1:0];
		end else if (sum < SMIN) begin
			res_n.saturated = 1'b1;
			res_n.interp_value = SMIN[DATA_W-1:0];
		end
	end

	assign sts.x_le = x_q <= $signed(rx);
	assign sts.x_ge = x_q >= $signed(rx);
	assign sts.span_gt1 = {1'b0, hi_q} > ({1'b0, lo_q} + (IDX_W+1)'(1));
	assign sts.div_last = dcnt_q == '0;
	assign sts.out_busy = res_valid_q && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(2);
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cnt_q <= cfg_data;
			end
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= req.query_x;
			last_q <= last_n;
			lo_q <= '0;
			hi_q <= last_n;
		end
		if (cmd.srch_upd) begin
			if (sts.x_le) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid;
			end
		end
		if (cmd.seg_first) begin
			a_q <= '0;
			b_hi_q <= 1'b0;
		end
		if (cmd.seg_last) begin
			a_q <= last_q - IDX_W'(1);
			b_hi_q <= 1'b1;
		end
		if (cmd.seg_lo) begin
			a_q <= lo_q;
			b_hi_q <= 1'b0;
		end
		if (cmd.cap_a) begin
			xa_q <= rx;
			ya_q <= ry;
		end
		if (cmd.cap_a1) begin
			xa1_q <= rx;
			ya1_q <= ry;
		end
		if (cmd.diff) begin
			dy_q <= (DATA_W+1)'(ya1_q) - (DATA_W+1)'(ya_q);
			dx_q <= (DATA_W+1)'(xa1_q) - (DATA_W+1)'(xa_q);
			ex_q <= (DATA_W+1)'(x_q) - (DATA_W+1)'(xb);
		end
		if (cmd.mul) begin
			num_q <= (2*DATA_W)'(mag33(dy_q)) * (2*DATA_W)'(mag33(ex_q));
			neg_q <= dy_q[DATA_W] ^ ex_q[DATA_W] ^ dx_q[DATA_W];
			dxz_q <= dx_q == '0;
			dmag_q <= mag33(dx_q);
		end
		if (cmd.div_init) begin
			ovf_q <= {3'b0, num_q} >= {dmag_q, {QBITS{1'b0}}};
			rem_q <= DATA_W'(num_q[2*DATA_W-1:QBITS]);
			nsh_q <= num_q[QBITS-1:0];
			quo_q <= '0;
			dcnt_q <= DCNT_W'(QBITS - 1);
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? DATA_W'(trial - {1'b0, dmag_q}) : trial[DATA_W-1:0];
			quo_q <= {quo_q[QBITS-2:0], trial_ge};
			nsh_q <= nsh_q << 1;
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
		if (cmd.finish) begin
			res_q <= res_n;
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

endmodule

FILE: rtl/tli_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing the search, multiply and divide.
module tli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_type,
	output logic              req_stall,
	input  tli_pkg::tli_sts_t sts,
	output tli_pkg::tli_cmd_t cmd
);
	import tli_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_FIRST,
		S_CK_FIRST,
		S_CK_LAST,
		S_SRCH,
		S_SRCH_CK,
		S_RD_A,
		S_RD_A1,
		S_CAP_A1,
		S_DIFF,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q, state_n;
	logic accept;

	assign req_stall = state_q != S_IDLE;
	assign accept = req_valid && !req_stall;

	always_comb begin
		cmd = '0;
		cmd.raddr = RA_ZERO;
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req_type == REQ_LOAD) begin
					cmd.load_wr = 1'b1;
				end
				if (accept && req_type == REQ_QUERY) begin
					cmd.start = 1'b1;
					state_n = S_RD_FIRST;
				end
			end
			S_RD_FIRST: begin
				cmd.raddr = RA_ZERO;
				state_n = S_CK_FIRST;
			end
			S_CK_FIRST: begin
				cmd.raddr = RA_LAST;
				if (sts.x_le) begin
					cmd.seg_first = 1'b1;
					state_n = S_RD_A;
				end else begin
					state_n = S_CK_LAST;
				end
			end
			S_CK_LAST: begin
				if (sts.x_ge) begin
					cmd.seg_last = 1'b1;
					state_n = S_RD_A;
				end else begin
					state_n = S_SRCH;
				end
			end
			S_SRCH: begin
				if (sts.span_gt1) begin
					cmd.raddr = RA_MID;
					state_n = S_SRCH_CK;
				end else begin
					cmd.seg_lo = 1'b1;
					state_n = S_RD_A;
				end
			end
			S_SRCH_CK: begin
				cmd.srch_upd = 1'b1;
				state_n = S_SRCH;
			end
			S_RD_A: begin
				cmd.raddr = RA_A;
				state_n = S_RD_A1;
			end
			S_RD_A1: begin
				cmd.raddr = RA_A1;
				cmd.cap_a = 1'b1;
				state_n = S_CAP_A1;
			end
			S_CAP_A1: begin
				cmd.cap_a1 = 1'b1;
				state_n = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_n = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_n = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_n = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

FILE: rtl/table_linear_interpolator.sv
`timescale 1ns / 1ps
// Top level of the table linear interpolator: controller, datapath and checks.
// A load request writes one table entry in the cycle it is accepted, and the next request
// can follow at once. A query request stalls the input until its result is registered:
// the binary search probes go through the single read port of the table memories, up
// to six probes, then a divider produces one quotient bit per cycle. The result waits
// in an output register, so a new request is accepted while an earlier result is still
// stalled.
module table_linear_interpolator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tli_pkg::tli_in_t          req,
	input  logic                      req_valid,
	output logic                      req_stall,
	output tli_pkg::tli_out_t         res,
	output logic                      res_valid,
	input  logic                      res_stall,
	input  logic                      cfg_we,
	input  logic [tli_pkg::CNT_W-1:0] cfg_data
);
	import tli_pkg::*;

	tli_cmd_t cmd;
	tli_sts_t sts;

	tli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tli_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(res_valid && res_stall))
		else $error("Result register overwritten while stalled.");

	a_one_segment: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.seg_first, cmd.seg_last, cmd.seg_lo}))
		else $error("More than one segment choice in a cycle.");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.req_type == REQ_QUERY) |=> req_stall)
		else $error("Query accepted without entering the busy state.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd.finish))
		else $error("Result appeared without a finish command.");

endmodule
